// ----- src/tpsd_pkg.sv -----
// Shared types and constants of the tape pulse stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package tpsd_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int MAGIC_BYTES  = 12;
    localparam int VERSION_POS  = 12;
    localparam int MACHINE_POS  = 13;
    localparam int VIDEO_POS    = 14;
    localparam int LENGTH_POS   = 16;
    localparam int EXT_BYTES    = 3;
    localparam int EXT_SPAN     = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LIMIT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_LIMIT = 1'd1;

    localparam logic [23:0] SHORT_LIMIT_RESET  = 24'd432;
    localparam logic [23:0] MEDIUM_LIMIT_RESET = 24'd592;

    localparam logic [2:0] KIND_PULSE       = 3'd0;
    localparam logic [2:0] KIND_HEADER      = 3'd1;
    localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] KIND_BAD_VERSION = 3'd3;
    localparam logic [2:0] KIND_TRUNCATED   = 3'd4;

    localparam logic [1:0] CLASS_SHORT  = 2'd0;
    localparam logic [1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [1:0] CLASS_LONG   = 2'd2;
    localparam logic [1:0] CLASS_ZERO   = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_EXT,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [7:0] tap_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [23:0] cycles;
        logic        long_pulse;
        logic [1:0]  pulse_class;
        logic [31:0] pulse_number;
        logic        format_version;
        logic [7:0]  machine_code;
        logic [7:0]  video_code;
    } out_word_t;

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h43;
            4'd1:    b = 8'h36;
            4'd2:    b = 8'h34;
            4'd3:    b = 8'h2D;
            4'd4:    b = 8'h54;
            4'd5:    b = 8'h41;
            4'd6:    b = 8'h50;
            4'd7:    b = 8'h45;
            4'd8:    b = 8'h2D;
            4'd9:    b = 8'h52;
            4'd10:   b = 8'h41;
            4'd11:   b = 8'h57;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- src/tap_pulse_stream_decoder.sv -----
// Top level of the tape pulse stream decoder: header check and pulse decode.
`timescale 1ns / 1ps
`default_nettype none

// Takes a tape image one byte per word and gives at most one result word per
// byte: the header verdict after byte 20, then one word per pulse. Every byte
// is decoded in the cycle it is accepted and the result lands in an output
// register, so one byte is taken every cycle while the result side keeps up;
// s_ready only drops while a result waits and m_ready is low. The user must
// write the two classification limits through the cfg port only while the
// stream is idle; the block itself does not enforce this.
module tap_pulse_stream_decoder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire tpsd_pkg::in_word_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output tpsd_pkg::out_word_t                      m_data,
    input  wire logic                                cfg_we,
    input  wire logic [tpsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tpsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [23:0]      short_limit_reg;
    logic [23:0]      medium_limit_reg;

    tpsd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]       header_count_reg, header_count_next;
    logic             magic_match_reg, magic_match_next;
    logic             version_ok_reg, version_ok_next;
    logic             image_version_reg, image_version_next;
    logic [7:0]       image_machine_reg, image_machine_next;
    logic [7:0]       image_video_reg, image_video_next;
    logic [31:0]      declared_length_reg, declared_length_next;
    logic [31:0]      data_consumed_reg, data_consumed_next;
    logic [23:0]      extended_value_reg, extended_value_next;
    logic [1:0]       extended_count_reg, extended_count_next;
    logic [31:0]      pulse_counter_reg, pulse_counter_next;

    logic                m_valid_reg;
    tpsd_pkg::out_word_t m_data_reg;

    logic                accept;
    logic [7:0]          b;
    logic                last;
    logic                hdr_final;
    logic                magic_now;
    logic                version_now;
    logic [31:0]         decl_final;
    logic [23:0]         ext_final;
    logic                ext_final_step;
    logic                remain_short;
    logic [23:0]         byte_cycles;
    logic                emit;
    tpsd_pkg::out_word_t out_word;

    function automatic logic [1:0] classify(input logic [23:0] c, input logic [23:0] s_lim,
                                            input logic [23:0] m_lim);
        logic [1:0] cls;
        priority if (c == 24'd0) begin
            cls = tpsd_pkg::CLASS_ZERO;
        end else if (c < s_lim) begin
            cls = tpsd_pkg::CLASS_SHORT;
        end else if (c < m_lim) begin
            cls = tpsd_pkg::CLASS_MEDIUM;
        end else begin
            cls = tpsd_pkg::CLASS_LONG;
        end
        return cls;
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.tap_byte;
    assign last    = s_data.last_byte;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign hdr_final   = header_count_reg == 5'(tpsd_pkg::HEADER_BYTES - 1);
    assign magic_now   = magic_match_reg &&
                         !(header_count_reg < 5'(tpsd_pkg::MAGIC_BYTES) &&
                           b != tpsd_pkg::magic_byte(header_count_reg[3:0]));
    assign version_now = version_ok_reg &&
                         !(header_count_reg == 5'(tpsd_pkg::VERSION_POS) && b > 8'd1);
    assign decl_final  = {b, declared_length_reg[23:0]};
    assign ext_final   = {b, extended_value_reg[15:0]};
    assign ext_final_step = extended_count_reg == 2'(tpsd_pkg::EXT_BYTES - 1);
    assign remain_short = (declared_length_reg - data_consumed_reg) <
                          32'(tpsd_pkg::EXT_SPAN);
    assign byte_cycles = {13'd0, b, 3'b000};

    // Next state
    always_comb begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        magic_match_next     = magic_match_reg;
        version_ok_next      = version_ok_reg;
        image_version_next   = image_version_reg;
        image_machine_next   = image_machine_reg;
        image_video_next     = image_video_reg;
        declared_length_next = declared_length_reg;
        data_consumed_next   = data_consumed_reg;
        extended_value_next  = extended_value_reg;
        extended_count_next  = extended_count_reg;
        pulse_counter_next   = pulse_counter_reg;

        unique case (phase_reg)
            tpsd_pkg::PH_HEADER: begin
                magic_match_next  = magic_now;
                version_ok_next   = version_now;
                header_count_next = header_count_reg + 5'd1;
                if (header_count_reg == 5'(tpsd_pkg::VERSION_POS)) begin
                    image_version_next = b[0];
                end
                if (header_count_reg == 5'(tpsd_pkg::MACHINE_POS)) begin
                    image_machine_next = b;
                end
                if (header_count_reg == 5'(tpsd_pkg::VIDEO_POS)) begin
                    image_video_next = b;
                end
                if (header_count_reg >= 5'(tpsd_pkg::LENGTH_POS)) begin
                    unique case (header_count_reg[1:0])
                        2'd0: declared_length_next[7:0]   = b;
                        2'd1: declared_length_next[15:8]  = b;
                        2'd2: declared_length_next[23:16] = b;
                        2'd3: declared_length_next[31:24] = b;
                        default: declared_length_next = declared_length_reg;
                    endcase
                end
                if (hdr_final) begin
                    if (!magic_now || !version_now || decl_final == 32'd0) begin
                        phase_next = tpsd_pkg::PH_SKIP;
                    end else begin
                        phase_next = tpsd_pkg::PH_DATA;
                    end
                end
            end
            tpsd_pkg::PH_DATA: begin
                if (b != 8'd0 || !image_version_reg) begin
                    pulse_counter_next = pulse_counter_reg + 32'd1;
                    data_consumed_next = data_consumed_reg + 32'd1;
                    phase_next = (data_consumed_next >= declared_length_reg) ?
                                 tpsd_pkg::PH_SKIP : tpsd_pkg::PH_DATA;
                end else if (remain_short || last) begin
                    phase_next = tpsd_pkg::PH_SKIP;
                end else begin
                    extended_value_next = 24'd0;
                    extended_count_next = 2'd0;
                    phase_next          = tpsd_pkg::PH_EXT;
                end
            end
            tpsd_pkg::PH_EXT: begin
                unique case (extended_count_reg)
                    2'd0:    extended_value_next[7:0]   = b;
                    2'd1:    extended_value_next[15:8]  = b;
                    default: extended_value_next[23:16] = b;
                endcase
                extended_count_next = extended_count_reg + 2'd1;
                if (ext_final_step) begin
                    pulse_counter_next  = pulse_counter_reg + 32'd1;
                    data_consumed_next  = data_consumed_reg + 32'(tpsd_pkg::EXT_SPAN);
                    extended_count_next = 2'd0;
                    phase_next = (data_consumed_next >= declared_length_reg) ?
                                 tpsd_pkg::PH_SKIP : tpsd_pkg::PH_DATA;
                end else if (last) begin
                    phase_next = tpsd_pkg::PH_SKIP;
                end
            end
            default: begin
                phase_next = tpsd_pkg::PH_SKIP;
            end
        endcase

        if (last) begin
            phase_next           = tpsd_pkg::PH_HEADER;
            header_count_next    = 5'd0;
            magic_match_next     = 1'b1;
            version_ok_next      = 1'b1;
            image_version_next   = 1'b0;
            image_machine_next   = 8'd0;
            image_video_next     = 8'd0;
            declared_length_next = 32'd0;
            data_consumed_next   = 32'd0;
            extended_value_next  = 24'd0;
            extended_count_next  = 2'd0;
            pulse_counter_next   = 32'd0;
        end
    end

    // Result word
    always_comb begin
        emit     = 1'b0;
        out_word = '0;
        unique case (phase_reg)
            tpsd_pkg::PH_HEADER: begin
                if (hdr_final) begin
                    emit = 1'b1;
                    priority if (!magic_now) begin
                        out_word.result_kind = tpsd_pkg::KIND_BAD_MAGIC;
                    end else if (!version_now) begin
                        out_word.result_kind = tpsd_pkg::KIND_BAD_VERSION;
                    end else begin
                        out_word.result_kind    = tpsd_pkg::KIND_HEADER;
                        out_word.format_version = image_version_reg;
                        out_word.machine_code   = image_machine_reg;
                        out_word.video_code     = image_video_reg;
                    end
                end else if (last) begin
                    emit                 = 1'b1;
                    out_word.result_kind = tpsd_pkg::KIND_TRUNCATED;
                end
            end
            tpsd_pkg::PH_DATA: begin
                if (b != 8'd0) begin
                    emit                  = 1'b1;
                    out_word.result_kind  = tpsd_pkg::KIND_PULSE;
                    out_word.cycles       = byte_cycles;
                    out_word.pulse_class  = classify(byte_cycles, short_limit_reg,
                                                     medium_limit_reg);
                    out_word.pulse_number = pulse_counter_reg;
                end else if (!image_version_reg) begin
                    emit                  = 1'b1;
                    out_word.result_kind  = tpsd_pkg::KIND_PULSE;
                    out_word.long_pulse   = 1'b1;
                    out_word.pulse_class  = tpsd_pkg::CLASS_ZERO;
                    out_word.pulse_number = pulse_counter_reg;
                end else if (remain_short || last) begin
                    emit                 = 1'b1;
                    out_word.result_kind = tpsd_pkg::KIND_TRUNCATED;
                end
            end
            tpsd_pkg::PH_EXT: begin
                if (ext_final_step) begin
                    emit                  = 1'b1;
                    out_word.result_kind  = tpsd_pkg::KIND_PULSE;
                    out_word.cycles       = ext_final;
                    out_word.pulse_class  = classify(ext_final, short_limit_reg,
                                                     medium_limit_reg);
                    out_word.pulse_number = pulse_counter_reg;
                end else if (last) begin
                    emit                 = 1'b1;
                    out_word.result_kind = tpsd_pkg::KIND_TRUNCATED;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_limit_reg     <= tpsd_pkg::SHORT_LIMIT_RESET;
            medium_limit_reg    <= tpsd_pkg::MEDIUM_LIMIT_RESET;
            phase_reg           <= tpsd_pkg::PH_HEADER;
            header_count_reg    <= 5'd0;
            magic_match_reg     <= 1'b1;
            version_ok_reg      <= 1'b1;
            image_version_reg   <= 1'b0;
            image_machine_reg   <= 8'd0;
            image_video_reg     <= 8'd0;
            declared_length_reg <= 32'd0;
            data_consumed_reg   <= 32'd0;
            extended_value_reg  <= 24'd0;
            extended_count_reg  <= 2'd0;
            pulse_counter_reg   <= 32'd0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tpsd_pkg::CFG_SHORT_LIMIT:  short_limit_reg  <= cfg_data;
                    tpsd_pkg::CFG_MEDIUM_LIMIT: medium_limit_reg <= cfg_data;
                    default: short_limit_reg <= short_limit_reg;
                endcase
            end
            if (accept) begin
                phase_reg           <= phase_next;
                header_count_reg    <= header_count_next;
                magic_match_reg     <= magic_match_next;
                version_ok_reg      <= version_ok_next;
                image_version_reg   <= image_version_next;
                image_machine_reg   <= image_machine_next;
                image_video_reg     <= image_video_next;
                declared_length_reg <= declared_length_next;
                data_consumed_reg   <= data_consumed_next;
                extended_value_reg  <= extended_value_next;
                extended_count_reg  <= extended_count_next;
                pulse_counter_reg   <= pulse_counter_next;
            end
            if (s_ready) begin
                m_valid_reg <= accept && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_data_reg <= out_word;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.last_byte) |=>
            (phase_reg == tpsd_pkg::PH_HEADER && header_count_reg == 5'd0))
        else $error("image state not cleared after last byte");

    a_ext_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tpsd_pkg::PH_EXT |-> extended_count_reg != 2'd3)
        else $error("extended count out of range");

    a_data_within_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == tpsd_pkg::PH_DATA || phase_reg == tpsd_pkg::PH_EXT) |->
            data_consumed_reg < declared_length_reg)
        else $error("data phase beyond declared length");

    a_long_pulse_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.long_pulse) |->
            (m_data_reg.pulse_class == tpsd_pkg::CLASS_ZERO &&
             m_data_reg.cycles == 24'd0))
        else $error("undefined long pulse carries a length");

    a_header_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tpsd_pkg::PH_HEADER |->
            header_count_reg < 5'(tpsd_pkg::HEADER_BYTES))
        else $error("header count past header");
`endif

endmodule

`default_nettype wire
